/* src/chpf_pkg.sv */
// Shared types, constants and helpers for the compass heading parser and filter.
package chpf_pkg;

	// Header text "HCHDM," and field characters
	localparam logic [7:0] CH_H      = 8'h48;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;

	localparam logic [2:0] HDR_LEN   = 3'd6;
	localparam logic [2:0] HDR_POS_D = 3'd3;

	// Field limits
	localparam int         MAX_FIELD_CHARS = 29;
	localparam logic [4:0] FIELD_LEN_SAT   = 5'd31;
	localparam logic [15:0] ACC_SAT        = 16'hFFFF;
	localparam logic [7:0] TICK_SAT        = 8'hFF;

	// Fractional parse progress
	localparam logic [1:0] FRAC_INT   = 2'd0;
	localparam logic [1:0] FRAC_POINT = 2'd1;
	localparam logic [1:0] FRAC_DONE  = 2'd2;

	// Heading arithmetic
	localparam logic [15:0] BATTERY_LOW_TENTHS = 16'd8000;
	localparam logic [11:0] FULL_TURN_TENTHS   = 12'd3600;
	localparam logic [11:0] MAX_TENTHS         = 12'd3599;
	localparam logic [23:0] RAD_SCALE          = 24'd14992264;
	localparam int          RAD_SHIFT          = 20;

	// Result status codes
	localparam logic [1:0] ST_VALID   = 2'd0;
	localparam logic [1:0] ST_BATTERY = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd0;
	localparam logic [1:0] REG_MOUNT_OFFSET  = 2'd1;
	localparam logic [1:0] REG_JUMP_LIMIT    = 2'd2;

	localparam logic [7:0]  RST_TIMEOUT_LIMIT = 8'd50;
	localparam logic [11:0] RST_MOUNT_OFFSET  = 12'd1800;
	localparam logic [11:0] RST_JUMP_LIMIT    = 12'd900;

	// Queue depths
	localparam int EVQ_DEPTH  = 4;
	localparam int OUTQ_DEPTH = 4;

	// Event handed from the parser to the filter
	typedef struct packed {
		logic        is_timeout;
		logic        neg;
		logic [15:0] mag;
	} evt_t;

	// Filter settings
	typedef struct packed {
		logic [11:0] mount_offset;
		logic [11:0] jump_limit;
	} cfg_t;

	// One finished result
	typedef struct packed {
		logic [11:0] tenths;
		logic [15:0] rad;
		logic [1:0]  status;
	} res_t;

	// Expected header character at a match position
	function automatic logic [7:0] hdr_char(input logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd0:    ch = CH_H;
			3'd1:    ch = CH_C;
			3'd2:    ch = CH_H;
			3'd3:    ch = CH_D;
			3'd4:    ch = CH_M;
			3'd5:    ch = CH_COMMA;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

/* src/chpf_front.sv */
// Byte parser: header hunt, heading field parse and poll tick timeout.
module chpf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 req_type,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           timeout_limit,
	output logic                 evt_valid,
	output chpf_pkg::evt_t       evt_data
);
	import chpf_pkg::*;

	logic [2:0]  header_pos_q, header_pos_d;
	logic        in_field_q, in_field_d;
	logic [4:0]  field_len_q, field_len_d;
	logic        negative_q, negative_d;
	logic [15:0] value_acc_q, value_acc_d;
	logic [1:0]  frac_state_q, frac_state_d;
	logic        number_done_q, number_done_d;
	logic [7:0]  tick_count_q, tick_count_d;

	logic [7:0]  tick_inc;
	logic [2:0]  hdr_nxt;
	logic        is_digit;
	logic [3:0]  digit;
	logic [16:0] int_sum;
	logic [20:0] int_val;
	logic [15:0] int_sat;
	logic [16:0] frac_sum;
	logic [15:0] frac_sat;
	logic        first_char;

	// Saturating tick counter
	assign tick_inc = (tick_count_q == TICK_SAT) ? tick_count_q : tick_count_q + 8'd1;

	// Header matcher with overlap on "HCH"
	always_comb begin
		if (rx_byte == hdr_char(header_pos_q)) begin
			hdr_nxt = header_pos_q + 3'd1;
		end else if (header_pos_q == HDR_POS_D && rx_byte == CH_C) begin
			hdr_nxt = 3'd2;
		end else begin
			hdr_nxt = (rx_byte == CH_H) ? 3'd1 : 3'd0;
		end
	end

	// Digit accumulate: whole degrees scale by ten, tenths add in
	assign is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign digit      = 4'(rx_byte - CH_ZERO);
	assign int_sum    = {1'b0, value_acc_q} + {13'd0, digit};
	assign int_val    = {1'b0, int_sum, 3'b000} + {3'b000, int_sum, 1'b0};
	assign int_sat    = (int_val > {5'd0, ACC_SAT}) ? ACC_SAT : int_val[15:0];
	assign frac_sum   = {1'b0, value_acc_q} + {13'd0, digit};
	assign frac_sat   = frac_sum[16] ? ACC_SAT : frac_sum[15:0];
	assign first_char = (field_len_q == 5'd0);

	// Next state
	always_comb begin
		header_pos_d  = header_pos_q;
		in_field_d    = in_field_q;
		field_len_d   = field_len_q;
		negative_d    = negative_q;
		value_acc_d   = value_acc_q;
		frac_state_d  = frac_state_q;
		number_done_d = number_done_q;
		tick_count_d  = tick_count_q;
		evt_valid     = 1'b0;
		evt_data      = '0;
		if (accept) begin
			if (req_type) begin
				if (tick_inc > timeout_limit) begin
					tick_count_d         = 8'd0;
					header_pos_d         = 3'd0;
					in_field_d           = 1'b0;
					field_len_d          = 5'd0;
					negative_d           = 1'b0;
					value_acc_d          = 16'd0;
					frac_state_d         = FRAC_INT;
					number_done_d        = 1'b0;
					evt_valid            = 1'b1;
					evt_data.is_timeout  = 1'b1;
				end else begin
					tick_count_d = tick_inc;
				end
			end else if (in_field_q) begin
				if (rx_byte == CH_COMMA) begin
					// End of field: hand off unless too long
					if (field_len_q <= 5'(MAX_FIELD_CHARS)) begin
						evt_valid    = 1'b1;
						evt_data.neg = negative_q;
						evt_data.mag = value_acc_q;
					end
					header_pos_d  = 3'd0;
					in_field_d    = 1'b0;
					field_len_d   = 5'd0;
					negative_d    = 1'b0;
					value_acc_d   = 16'd0;
					frac_state_d  = FRAC_INT;
					number_done_d = 1'b0;
				end else begin
					if (field_len_q != FIELD_LEN_SAT) begin
						field_len_d = field_len_q + 5'd1;
					end
					if (!number_done_q) begin
						if (is_digit) begin
							if (frac_state_q == FRAC_INT) begin
								value_acc_d = int_sat;
							end else if (frac_state_q == FRAC_POINT) begin
								value_acc_d  = frac_sat;
								frac_state_d = FRAC_DONE;
							end
						end else if (rx_byte == CH_POINT && frac_state_q == FRAC_INT) begin
							frac_state_d = FRAC_POINT;
						end else if (first_char &&
								(rx_byte == CH_MINUS || rx_byte == CH_PLUS)) begin
							negative_d = (rx_byte == CH_MINUS);
						end else begin
							number_done_d = 1'b1;
						end
					end
				end
			end else begin
				if (hdr_nxt == HDR_LEN) begin
					// Header found: open a fresh field
					header_pos_d  = 3'd0;
					in_field_d    = 1'b1;
					field_len_d   = 5'd0;
					negative_d    = 1'b0;
					value_acc_d   = 16'd0;
					frac_state_d  = FRAC_INT;
					number_done_d = 1'b0;
					tick_count_d  = 8'd0;
				end else begin
					header_pos_d = hdr_nxt;
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_pos_q  <= 3'd0;
			in_field_q    <= 1'b0;
			field_len_q   <= 5'd0;
			negative_q    <= 1'b0;
			value_acc_q   <= 16'd0;
			frac_state_q  <= FRAC_INT;
			number_done_q <= 1'b0;
			tick_count_q  <= 8'd0;
		end else begin
			header_pos_q  <= header_pos_d;
			in_field_q    <= in_field_d;
			field_len_q   <= field_len_d;
			negative_q    <= negative_d;
			value_acc_q   <= value_acc_d;
			frac_state_q  <= frac_state_d;
			number_done_q <= number_done_d;
			tick_count_q  <= tick_count_d;
		end
	end

	// Checks
	a_hdr_range: assert property (@(posedge clk) disable iff (!arst_n)
		header_pos_q < HDR_LEN)
		else $error("header position out of range");
	a_field_no_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		in_field_q |-> header_pos_q == 3'd0)
		else $error("header progress kept inside a field");
	a_frac_code: assert property (@(posedge clk) disable iff (!arst_n)
		frac_state_q != 2'd3)
		else $error("bad fraction state");
	a_evt_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> accept)
		else $error("event without an accepted beat");
	a_field_after_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_field_q) |-> tick_count_q == 8'd0 && value_acc_q == 16'd0)
		else $error("field opened without clearing");

endmodule

/* src/chpf_evq.sv */
// Event queue between the parser and the filter.
module chpf_evq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  chpf_pkg::evt_t push_data,
	output logic           full,
	input  logic           pop,
	output chpf_pkg::evt_t head,
	output logic           empty
);
	import chpf_pkg::*;

	localparam int PW = $clog2(EVQ_DEPTH);
	localparam int CW = $clog2(EVQ_DEPTH + 1);

	evt_t          mem_q [EVQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(EVQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(EVQ_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(EVQ_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("event queue overflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(EVQ_DEPTH))
		else $error("event queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CW'(EVQ_DEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("event queue pointers disagree with count");

endmodule

/* src/chpf_back.sv */
// Filter back end: offset, wrap, smoothing, radian scaling and result queue.
module chpf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  chpf_pkg::cfg_t cfg,
	input  logic           evq_empty,
	input  chpf_pkg::evt_t evq_head,
	output logic           evq_pop,
	output logic           empty,
	input  logic           pop,
	output logic [11:0]    heading_tenths,
	output logic [15:0]    heading_rad,
	output logic [1:0]     status
);
	import chpf_pkg::*;

	localparam int PW = $clog2(OUTQ_DEPTH);
	localparam int CW = $clog2(OUTQ_DEPTH + 1);

	logic               valid_s1;
	logic [11:0]        tenths_s1;
	logic [1:0]         status_s1;
	logic [11:0]        prev_heading_q;
	logic               prev_valid_q;

	logic signed [17:0] mag_ext, raw, h0, h1;
	logic [11:0]        hv, diff, res_tenths;
	logic [12:0]        avg_sum;
	logic               battery;
	logic [11:0]        new_tenths;
	logic [1:0]         new_status;
	logic [35:0]        rad_prod;
	logic [15:0]        rad_val;

	res_t               outq_q [OUTQ_DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]      count_q;
	logic [CW:0]        pending;
	logic               do_pop;
	res_t               head;

	// Take an event only when the result queue has room for it
	assign pending = {1'b0, count_q} + {{CW{1'b0}}, valid_s1};
	assign evq_pop = !evq_empty && (pending < (CW + 1)'(OUTQ_DEPTH));

	// Signed reading, offset and single wrap, then clamp
	assign mag_ext = $signed({2'b00, evq_head.mag});
	assign raw     = evq_head.neg ? -mag_ext : mag_ext;
	assign h0      = raw - $signed({6'd0, cfg.mount_offset});
	assign h1      = h0[17] ? h0 + $signed({6'd0, FULL_TURN_TENTHS}) : h0;
	assign battery = !evq_head.neg && (evq_head.mag == BATTERY_LOW_TENTHS);

	always_comb begin
		if (h1[17]) begin
			hv = 12'd0;
		end else if (h1 > $signed({6'd0, MAX_TENTHS})) begin
			hv = MAX_TENTHS;
		end else begin
			hv = h1[11:0];
		end
	end

	// Smoothing against the previous raw heading
	assign diff    = (prev_heading_q > hv) ? prev_heading_q - hv : hv - prev_heading_q;
	assign avg_sum = {1'b0, prev_heading_q} + {1'b0, hv};
	assign res_tenths = (!prev_valid_q || diff > cfg.jump_limit) ? hv : avg_sum[12:1];

	// Result selection by event kind
	always_comb begin
		if (evq_head.is_timeout) begin
			new_tenths = 12'd0;
			new_status = ST_TIMEOUT;
		end else if (battery) begin
			new_tenths = 12'd0;
			new_status = ST_BATTERY;
		end else begin
			new_tenths = res_tenths;
			new_status = ST_VALID;
		end
	end

	// Stage 1 control and filter memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			prev_heading_q <= 12'd0;
			prev_valid_q   <= 1'b0;
		end else begin
			valid_s1 <= evq_pop;
			if (evq_pop && !evq_head.is_timeout && !battery) begin
				prev_heading_q <= hv;
				prev_valid_q   <= 1'b1;
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (evq_pop) begin
			tenths_s1 <= new_tenths;
			status_s1 <= new_status;
		end
	end

	// Radians in Q3.13, rounded
	assign rad_prod = {24'd0, tenths_s1} * {12'd0, RAD_SCALE}
		+ (36'd1 << (RAD_SHIFT - 1));
	assign rad_val  = rad_prod[RAD_SHIFT +: 16];

	// Result queue
	assign empty  = (count_q == '0);
	assign do_pop = pop && !empty;
	assign head   = outq_q[rd_ptr_q];
	assign heading_tenths = head.tenths;
	assign heading_rad    = head.rad;
	assign status         = head.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= (wr_ptr_q == PW'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (valid_s1 && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !valid_s1) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			outq_q[wr_ptr_q] <= '{tenths: tenths_s1, rad: rad_val, status: status_s1};
		end
	end

	// Checks
	a_outq_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> count_q < CW'(OUTQ_DEPTH))
		else $error("result queue overflow");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && status_s1 != ST_VALID) |-> tenths_s1 == 12'd0)
		else $error("error result carries a heading");
	a_tenths_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> tenths_s1 <= MAX_TENTHS)
		else $error("heading out of range");
	a_prev_range: assert property (@(posedge clk) disable iff (!arst_n)
		prev_valid_q |-> prev_heading_q <= MAX_TENTHS)
		else $error("stored heading out of range");

endmodule

/* src/compass_heading_parse_filter_top.sv */
// A closing comma or timing-out tick accepted on the input passes through the event queue, the
// filter register and the result queue, in that order, before it is on the result ports.
// One beat per cycle in unless full, out unless empty; the parser steps only on accepted beats.
// The parser, a 4-entry event queue and a filter with one pipeline stage ahead of a 4-entry
// result queue run decoupled. full rises only when the event queue is full.
// Reset (arst_n low, asynchronous) empties both queues, clears parse and filter state and
// loads the register defaults: timeout 50 ticks, mount offset 1800, jump limit 900.
module compass_heading_parse_filter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        req_type,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [11:0] heading_tenths,
	output logic [15:0] heading_rad,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import chpf_pkg::*;

	logic [7:0]  timeout_limit_q;
	logic [11:0] mount_offset_q;
	logic [11:0] jump_limit_q;
	cfg_t        cfg;
	logic        accept;
	logic        evt_valid;
	evt_t        evt_data;
	logic        evq_full, evq_empty, evq_pop;
	evt_t        evq_head;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_limit_q <= RST_TIMEOUT_LIMIT;
			mount_offset_q  <= RST_MOUNT_OFFSET;
			jump_limit_q    <= RST_JUMP_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_data[7:0];
				REG_MOUNT_OFFSET:  mount_offset_q  <= cfg_data;
				REG_JUMP_LIMIT:    jump_limit_q    <= cfg_data;
				default:           ;
			endcase
		end
	end

	assign cfg = '{mount_offset: mount_offset_q, jump_limit: jump_limit_q};

	// Input beat acceptance
	assign full   = evq_full;
	assign accept = push && !evq_full;

	chpf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.req_type      (req_type),
		.rx_byte       (rx_byte),
		.timeout_limit (timeout_limit_q),
		.evt_valid     (evt_valid),
		.evt_data      (evt_data)
	);

	chpf_evq u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (evt_valid),
		.push_data (evt_data),
		.full      (evq_full),
		.pop       (evq_pop),
		.head      (evq_head),
		.empty     (evq_empty)
	);

	chpf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.evq_empty      (evq_empty),
		.evq_head       (evq_head),
		.evq_pop        (evq_pop),
		.empty          (empty),
		.pop            (pop),
		.heading_tenths (heading_tenths),
		.heading_rad    (heading_rad),
		.status         (status)
	);

endmodule
